[design/wsd_pkg.sv]
// Package for the WebSocket frame deframer: parser phase codes, result kinds,
// opcodes and the result word type. Used by every module of the block.
`default_nettype none

package wsd_pkg;

    localparam int LENGTH_BITS = 64;

    localparam logic [2:0] PH_HDR1    = 3'd0;
    localparam logic [2:0] PH_HDR2    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_PING   = 4'h9;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [2:0] KEY_BYTES   = 3'd4;

    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_PONG    = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload;
        logic       last;
        logic       is_binary;
    } result_t;

endpackage

`default_nettype wire

[design/wsd_in_reg.sv]
// Input register of the deframer: holds one accepted stream word until the
// parser takes it. Depends on wsd_pkg.
`default_nettype none

module wsd_in_reg
    import wsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       in_action,
    input  wire logic [7:0] in_byte,
    input  wire logic       advance,
    output logic            item_valid,
    output logic            item_action,
    output logic [7:0]      item_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic       action_reg;
    logic [7:0] byte_reg;
    logic       load;

    assign in_ready = !valid_reg || advance;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            action_reg <= in_action;
            byte_reg   <= in_byte;
        end
    end

    assign item_valid  = valid_reg;
    assign item_action = action_reg;
    assign item_byte   = byte_reg;

endmodule

`default_nettype wire

[design/wsd_parser.sv]
// Frame parser of the deframer: header, extended length, mask key and payload
// state with the combinational update for one word. Depends on wsd_pkg.
`default_nettype none

module wsd_parser
    import wsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire logic       action,
    input  wire logic [7:0] data_byte,
    output logic            res_valid,
    output result_t         res
);

    logic [2:0]             phase_reg,        phase_next;
    logic [3:0]             opcode_reg,       opcode_next;
    logic                   mask_present_reg, mask_present_next;
    logic [3:0]             ext_left_reg,     ext_left_next;
    logic [31:0]            mask_key_reg,     mask_key_next;
    logic [2:0]             key_left_reg,     key_left_next;
    logic [LENGTH_BITS-1:0] remaining_reg,    remaining_next;
    logic [1:0]             mask_index_reg,   mask_index_next;
    logic                   error_hold_reg,   error_hold_next;

    logic                   length_done;
    logic                   header_done;
    logic [1:0]             key_sel;
    logic [7:0]             key_byte;
    logic [7:0]             unmasked;
    logic [LENGTH_BITS-1:0] remaining_dec;
    logic                   is_bin;

    assign key_sel       = ~mask_index_reg;
    assign key_byte      = mask_key_reg[{key_sel, 3'b000} +: 8];
    assign unmasked      = mask_present_reg ? (data_byte ^ key_byte) : data_byte;
    assign remaining_dec = remaining_reg - LENGTH_BITS'(1);
    assign is_bin        = (opcode_reg == OP_BINARY);

    always_comb
    begin
        phase_next        = phase_reg;
        opcode_next       = opcode_reg;
        mask_present_next = mask_present_reg;
        ext_left_next     = ext_left_reg;
        mask_key_next     = mask_key_reg;
        key_left_next     = key_left_reg;
        remaining_next    = remaining_reg;
        mask_index_next   = mask_index_reg;
        error_hold_next   = error_hold_reg;
        length_done       = 1'b0;
        header_done       = 1'b0;
        res_valid         = 1'b0;
        res               = '{kind: KIND_PAYLOAD, payload: 8'd0, last: 1'b0, is_binary: 1'b0};

        if (fire)
        begin
            if (action == ACT_RESTART)
            begin
                phase_next        = PH_HDR1;
                opcode_next       = 4'd0;
                mask_present_next = 1'b0;
                ext_left_next     = 4'd0;
                mask_key_next     = 32'd0;
                key_left_next     = 3'd0;
                remaining_next    = '0;
                mask_index_next   = 2'd0;
                error_hold_next   = 1'b0;
            end
            else if (!error_hold_reg)
            begin
                unique case (phase_reg)
                    PH_HDR2:
                    begin
                        mask_present_next = data_byte[7];
                        remaining_next    = '0;
                        if (data_byte[6:0] == LEN7_EXT16)
                        begin
                            ext_left_next = EXT16_BYTES;
                            phase_next    = PH_EXTLEN;
                        end
                        else if (data_byte[6:0] == LEN7_EXT64)
                        begin
                            ext_left_next = EXT64_BYTES;
                            phase_next    = PH_EXTLEN;
                        end
                        else
                        begin
                            remaining_next = LENGTH_BITS'(data_byte[6:0]);
                            length_done    = 1'b1;
                        end
                    end
                    PH_EXTLEN:
                    begin
                        if (remaining_reg[LENGTH_BITS-1 -: 8] != 8'd0)
                        begin
                            error_hold_next = 1'b1;
                            res_valid       = 1'b1;
                            res.kind        = KIND_ERROR;
                        end
                        else
                        begin
                            remaining_next = {remaining_reg[LENGTH_BITS-9:0], data_byte};
                            ext_left_next  = ext_left_reg - 4'd1;
                            length_done    = (ext_left_next == 4'd0);
                        end
                    end
                    PH_MASK:
                    begin
                        mask_key_next = {mask_key_reg[23:0], data_byte};
                        key_left_next = key_left_reg - 3'd1;
                        header_done   = (key_left_next == 3'd0);
                    end
                    PH_PAYLOAD:
                    begin
                        mask_index_next = mask_index_reg + 2'd1;
                        remaining_next  = remaining_dec;
                        if (remaining_dec == '0)
                        begin
                            phase_next = PH_HDR1;
                        end
                        if (opcode_reg == OP_PING)
                        begin
                            if (remaining_dec == '0)
                            begin
                                res_valid = 1'b1;
                                res.kind  = KIND_PONG;
                            end
                        end
                        else
                        begin
                            res_valid     = 1'b1;
                            res.kind      = KIND_PAYLOAD;
                            res.payload   = unmasked;
                            res.last      = (remaining_dec == '0);
                            res.is_binary = is_bin;
                        end
                    end
                    default:
                    begin
                        if (data_byte[3:0] != OP_TEXT && data_byte[3:0] != OP_BINARY
                            && data_byte[3:0] != OP_PING)
                        begin
                            error_hold_next = 1'b1;
                            res_valid       = 1'b1;
                            res.kind        = KIND_ERROR;
                        end
                        else
                        begin
                            opcode_next = data_byte[3:0];
                            phase_next  = PH_HDR2;
                        end
                    end
                endcase

                if (length_done)
                begin
                    if (mask_present_next)
                    begin
                        phase_next    = PH_MASK;
                        key_left_next = KEY_BYTES;
                        mask_key_next = 32'd0;
                    end
                    else
                    begin
                        header_done = 1'b1;
                    end
                end

                if (header_done)
                begin
                    if (remaining_next != '0)
                    begin
                        phase_next      = PH_PAYLOAD;
                        mask_index_next = 2'd0;
                    end
                    else
                    begin
                        phase_next = PH_HDR1;
                        res_valid  = 1'b1;
                        if (opcode_next == OP_PING)
                        begin
                            res.kind = KIND_PONG;
                        end
                        else
                        begin
                            res.kind      = KIND_EMPTY;
                            res.last      = 1'b1;
                            res.is_binary = (opcode_next == OP_BINARY);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HDR1;
            opcode_reg       <= 4'd0;
            mask_present_reg <= 1'b0;
            ext_left_reg     <= 4'd0;
            mask_key_reg     <= 32'd0;
            key_left_reg     <= 3'd0;
            remaining_reg    <= '0;
            mask_index_reg   <= 2'd0;
            error_hold_reg   <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            opcode_reg       <= opcode_next;
            mask_present_reg <= mask_present_next;
            ext_left_reg     <= ext_left_next;
            mask_key_reg     <= mask_key_next;
            key_left_reg     <= key_left_next;
            remaining_reg    <= remaining_next;
            mask_index_reg   <= mask_index_next;
            error_hold_reg   <= error_hold_next;
        end
    end

endmodule

`default_nettype wire

[design/wsd_out_reg.sv]
// Result register of the deframer: holds one result word until the sink takes
// it. Depends on wsd_pkg.
`default_nettype none

module wsd_out_reg
    import wsd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    advance,
    input  wire logic    res_valid,
    input  wire result_t res,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = res_valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

[design/websocket_frame_deframer_unit.sv]
// Top level of the WebSocket frame deframer: input register, frame parser and
// result register. Depends on wsd_pkg, wsd_in_reg, wsd_parser and wsd_out_reg.
`default_nettype none

// The block takes one stream word per clock cycle while the sink does not stall
// it through m_axis_tready, and gives at most one result word for it: the word
// is held in the input register, passed through the combinational parser update
// and then registered in the result register. A tuser of one on the input
// restarts the parser and clears a held protocol error. After an error, stream
// words are taken and dropped until a restart.
module websocket_frame_deframer_unit
    import wsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // data_byte
    input  wire logic [0:0]  s_axis_tuser,  // action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // payload
    output logic [2:0]       m_axis_tuser,  // kind, is_binary
    output logic             m_axis_tlast
);

    logic       advance;
    logic       item_valid;
    logic       item_action;
    logic [7:0] item_byte;
    logic       res_valid;
    result_t    res;
    logic       out_valid;
    result_t    out_res;

    assign advance = item_valid && (!out_valid || m_axis_tready);

    wsd_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_action   (s_axis_tuser[0]),
        .in_byte     (s_axis_tdata),
        .advance     (advance),
        .item_valid  (item_valid),
        .item_action (item_action),
        .item_byte   (item_byte)
    );

    wsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .action    (item_action),
        .data_byte (item_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    wsd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = out_res.payload;
    assign m_axis_tuser  = {out_res.is_binary, out_res.kind};
    assign m_axis_tlast  = out_res.last;

endmodule

`default_nettype wire
